[design/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and arithmetic helpers of the skinning engine.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int DW             = 32;
	localparam int ACC_W          = 50;
	localparam int SLOT_W         = 7;
	localparam int ELEM_W         = 4;
	localparam int BONES_W        = 32;
	localparam int WGTS_W         = 64;
	localparam int BONE_W         = 8;
	localparam int WGT_W          = 16;
	localparam int FIELD_INF      = 4;
	localparam int MAX_BONES_DEF  = 64;
	localparam int INFLUENCES_DEF = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 7;
	localparam int IN_TDATA_W     = 336;
	localparam int OUT_TDATA_W    = 192;

	localparam logic [CFG_IDX_W-1:0] CFG_BONE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HAS_NORMAL = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_SKIN = 1'b1;

	localparam logic signed [DW-1:0] ONE_Q16 = 32'sd65536;

	typedef struct packed {
		logic                  op;
		logic                  load_ok;
		logic [SLOT_W-1:0]     slot;
		logic [ELEM_W-1:0]     elem;
		logic [DW-1:0]         value;
		logic [2:0][DW-1:0]    pos;
		logic [2:0][DW-1:0]    nrm;
		logic [BONES_W-1:0]    bones;
		logic [WGTS_W-1:0]     weights;
	} item_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} q_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_ISSUE, BK_DRAIN, BK_PICK, BK_NORM, BK_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		PH_BIND, PH_BONE, PH_WT, PH_INV, PH_SQ
	} phase_t;

	typedef enum logic [2:0] {
		NM_IDLE, NM_SQRT, NM_SETUP, NM_DIV, NM_DONE
	} norm_state_t;

	typedef enum logic [1:0] {
		MK_XF, MK_WT, MK_SQ
	} mac_kind_t;

	typedef struct packed {
		logic      v;
		mac_kind_t kind;
		logic [1:0] row;
		logic      last;
	} mac_tag_t;

	// floor((p + 2^15) / 2^16)
	function automatic logic signed [ACC_W-1:0] round16(input logic signed [2*DW-1:0] p);
		logic signed [2*DW-1:0] s;
		s = p + 64'sd32768;
		return ACC_W'(s >>> 16);
	endfunction

	function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DW:0] hi;
		hi = v[ACC_W-1:DW-1];
		if (hi == '0 || hi == '1) begin
			return v[DW-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(DW-1){1'b0}}};
		end else begin
			return {1'b0, {(DW-1){1'b1}}};
		end
	endfunction

endpackage

[design/lbs_ram.sv]
// ----------------------------------------------------------------------------
// lbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lbs_ram #(
	parameter int W = 32,
	parameter int D = 1056
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/lbs_front.sv]
// ----------------------------------------------------------------------------
// lbs_front
// Input side: unpacks and classifies transactions into a two-entry queue.
// ----------------------------------------------------------------------------
module lbs_front import lbs_pkg::*; #(
	parameter int MAX_BONES = MAX_BONES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  s_tuser,
	input  logic                  pop,
	output item_t                 head,
	output q_stat_t               stat
);

	localparam int SLOTS    = MAX_BONES + 2;
	localparam int ELEM_LSB = SLOT_W;
	localparam int VAL_LSB  = ELEM_LSB + ELEM_W;
	localparam int POS_LSB  = VAL_LSB + DW;
	localparam int NRM_LSB  = POS_LSB + 3 * DW;
	localparam int BON_LSB  = NRM_LSB + 3 * DW;
	localparam int WGT_LSB  = BON_LSB + BONES_W;

	item_t      in_item;
	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	always_comb begin
		in_item.op      = s_tuser;
		in_item.slot    = s_tdata[SLOT_W-1:0];
		in_item.elem    = s_tdata[ELEM_LSB +: ELEM_W];
		in_item.value   = s_tdata[VAL_LSB +: DW];
		for (int k = 0; k < 3; k++) begin
			in_item.pos[k] = s_tdata[POS_LSB + k * DW +: DW];
			in_item.nrm[k] = s_tdata[NRM_LSB + k * DW +: DW];
		end
		in_item.bones   = s_tdata[BON_LSB +: BONES_W];
		in_item.weights = s_tdata[WGT_LSB +: WGTS_W];
		in_item.load_ok = (s_tuser == OP_LOAD) && (32'(in_item.slot) < 32'(SLOTS));
	end

	assign s_tready    = (count_q != 2'd2);
	assign push        = s_tvalid && s_tready;
	assign head        = mem_q[rd_ptr_q];
	assign stat.full   = (count_q == 2'd2);
	assign stat.empty  = (count_q == 2'd0);
	assign stat.count  = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[design/lbs_norm.sv]
// ----------------------------------------------------------------------------
// lbs_norm
// Normal normalizer: bitwise integer square root, then three restoring
// divisions producing Q16.16 unit components; a zero length passes the input through.
// ----------------------------------------------------------------------------
module lbs_norm import lbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2*DW-1:0]      sumsq,
	input  logic signed [DW-1:0] t [3],
	output logic                 done,
	output logic signed [DW-1:0] rn [3]
);

	localparam int REM_W = 49;
	localparam int Q_W   = 17;

	norm_state_t state_q, state_d;

	logic [2*DW-1:0]      v_q;
	logic [2*DW-1:0]      r_q;
	logic [2*DW-1:0]      bit_q;
	logic [2*DW-1:0]      r_plus;
	logic signed [DW-1:0] t_q [3];
	logic [1:0]           k_q;
	logic [4:0]           j_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     dsh_q;
	logic [Q_W-1:0]       q_q;
	logic [Q_W-1:0]       q_next;
	logic [DW-1:0]        len;
	logic [DW-1:0]        mag;
	logic                 ge;

	assign r_plus = r_q + bit_q;
	assign len    = r_q[DW-1:0];
	assign mag    = t_q[k_q][DW-1] ? DW'(-t_q[k_q]) : DW'(t_q[k_q]);
	assign ge     = (rem_q >= dsh_q);
	assign q_next = {q_q[Q_W-2:0], ge};
	assign done   = (state_q == NM_DONE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			NM_IDLE: begin
				if (start) begin
					state_d = NM_SQRT;
				end
			end
			NM_SQRT: begin
				if (bit_q == 64'd1) begin
					state_d = NM_SETUP;
				end
			end
			NM_SETUP: begin
				if (len == '0) begin
					state_d = NM_DONE;
				end else begin
					state_d = NM_DIV;
				end
			end
			NM_DIV: begin
				if (j_q == 5'd0) begin
					state_d = (k_q == 2'd2) ? NM_DONE : NM_SETUP;
				end
			end
			NM_DONE: state_d = NM_IDLE;
			default: state_d = NM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= NM_IDLE;
			k_q     <= 2'd0;
			j_q     <= 5'd0;
		end else begin
			state_q <= state_d;
			if (state_q == NM_IDLE && start) begin
				k_q <= 2'd0;
			end
			if (state_q == NM_SETUP) begin
				j_q <= 5'd16;
			end
			if (state_q == NM_DIV) begin
				j_q <= j_q - 5'd1;
				if (j_q == 5'd0) begin
					k_q <= k_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == NM_IDLE && start) begin
			v_q   <= sumsq;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
			for (int k = 0; k < 3; k++) begin
				t_q[k] <= t[k];
			end
		end
		if (state_q == NM_SQRT) begin
			if (v_q >= r_plus) begin
				v_q <= v_q - r_plus;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == NM_SETUP) begin
			rem_q <= (REM_W'(mag) << 16) + REM_W'(len >> 1);
			dsh_q <= REM_W'(len) << 16;
			q_q   <= '0;
			if (len == '0) begin
				for (int k = 0; k < 3; k++) begin
					rn[k] <= t_q[k];
				end
			end
		end
		if (state_q == NM_DIV) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			q_q   <= q_next;
			if (j_q == 5'd0) begin
				rn[k_q] <= t_q[k_q][DW-1] ? -DW'(q_next) : DW'(q_next);
			end
		end
	end

endmodule

[design/lbs_back.sv]
// ----------------------------------------------------------------------------
// lbs_back
// Execution side: matrix loads, multiply-accumulate sequencer over the
// matrix store, normalization and the output register.
// ----------------------------------------------------------------------------
module lbs_back import lbs_pkg::*; #(
	parameter int MAX_BONES  = MAX_BONES_DEF,
	parameter int INFLUENCES = INFLUENCES_DEF,
	parameter int AW         = $clog2((MAX_BONES + 2) * 16)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  item_t                  head,
	input  q_stat_t                stat,
	output logic                   pop,
	output logic                   ram_we,
	output logic [AW-1:0]          ram_waddr,
	output logic [DW-1:0]          ram_wdata,
	output logic [AW-1:0]          ram_raddr,
	input  logic [DW-1:0]          ram_rdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int SLOTS   = MAX_BONES + 2;
	localparam int SLOT_AW = AW - 4;
	localparam int IW      = $clog2(INFLUENCES + 1);

	back_state_t state_q, state_d;
	phase_t      phase_q;

	logic [6:0]          bone_count_q;
	logic                has_normal_q;
	logic [8:0]          nb;
	logic                pass_q;
	logic [1:0]          row_q, col_q;
	logic [IW-1:0]       inf_q;
	logic [SLOT_AW-1:0]  slot_q;
	logic [WGT_W-1:0]    weight_q;
	item_t               cur_q;

	logic signed [DW-1:0]    res_q [3];
	logic signed [DW-1:0]    bp_q [3];
	logic signed [DW-1:0]    pos_out_q [3];
	logic signed [DW-1:0]    rn_q [3];
	logic signed [DW-1:0]    vec [3];
	logic signed [DW-1:0]    nrm_res [3];
	logic signed [ACC_W-1:0] accw_q [3];
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] rnd;
	logic [2*DW-1:0]         sumsq_q;

	mac_tag_t               tag_new, tag_s1, tag_s2;
	logic signed [DW-1:0]   a_new, b_new, a_s1, b_s1, mult_a;
	logic signed [2*DW-1:0] prod_s2;

	logic                  is_xf, last_op, issue, drained, norm_start, norm_done;
	logic                  out_load, inf_done, inf_ok, start_vtx;
	logic [1:0]            last_col;
	logic [SLOT_AW-1:0]    xslot;
	logic [BONE_W-1:0]     b_sel;
	logic [WGT_W-1:0]      w_sel;
	logic [OUT_TDATA_W-1:0] out_q;

	assign nb = (9'(bone_count_q) < 9'(MAX_BONES)) ? 9'(bone_count_q) : 9'(MAX_BONES);

	assign is_xf    = (phase_q == PH_BIND) || (phase_q == PH_BONE) || (phase_q == PH_INV);
	assign last_col = (is_xf && !pass_q) ? 2'd3 : 2'd2;
	assign last_op  = is_xf ? (row_q == 2'd2 && col_q == last_col) : (col_q == 2'd2);
	assign drained  = !tag_s1.v && !tag_s2.v;
	assign inf_done = (inf_q == IW'(INFLUENCES));
	assign inf_ok   = (w_sel != '0) && (9'(b_sel) < nb);
	assign start_vtx = (state_q == BK_IDLE) && pop && (head.op == OP_SKIN);

	always_comb begin
		b_sel = '0;
		w_sel = '0;
		for (int j = 0; j < FIELD_INF; j++) begin
			if (32'(inf_q) == j) begin
				b_sel = cur_q.bones[j * BONE_W +: BONE_W];
				w_sel = cur_q.weights[j * WGT_W +: WGT_W];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			unique case (phase_q)
				PH_BIND: vec[k] = pass_q ? $signed(cur_q.nrm[k]) : $signed(cur_q.pos[k]);
				PH_BONE: vec[k] = bp_q[k];
				default: vec[k] = sat32(accw_q[k]);
			endcase
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_BIND: xslot = SLOT_AW'(MAX_BONES);
			PH_INV:  xslot = SLOT_AW'(MAX_BONES + 1);
			default: xslot = slot_q;
		endcase
		ram_raddr    = {xslot, col_q, row_q};
		tag_new.v    = 1'b1;
		tag_new.last = (col_q == last_col);
		tag_new.row  = is_xf ? row_q : col_q;
		a_new        = res_q[col_q];
		unique case (phase_q)
			PH_WT: begin
				tag_new.kind = MK_WT;
				b_new        = $signed({{(DW-WGT_W){1'b0}}, weight_q});
			end
			PH_SQ: begin
				tag_new.kind = MK_SQ;
				b_new        = res_q[col_q];
			end
			default: begin
				tag_new.kind = MK_XF;
				b_new        = (col_q == 2'd3) ? ONE_Q16 : vec[col_q];
			end
		endcase
	end

	assign ram_waddr = {SLOT_AW'(head.slot), head.elem};
	assign ram_wdata = head.value;
	assign mult_a    = (tag_s1.kind == MK_XF) ? $signed(ram_rdata) : a_s1;
	assign rnd       = round16(prod_s2);

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		ram_we     = 1'b0;
		issue      = 1'b0;
		norm_start = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					if (head.op == OP_LOAD) begin
						ram_we = head.load_ok;
					end else if (nb == '0) begin
						state_d = BK_OUT;
					end else begin
						state_d = BK_ISSUE;
					end
				end
			end
			BK_ISSUE: begin
				issue = 1'b1;
				if (last_op) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (drained) begin
					unique case (phase_q)
						PH_BIND: state_d = BK_PICK;
						PH_BONE: state_d = BK_ISSUE;
						PH_WT:   state_d = BK_PICK;
						PH_INV: begin
							if (pass_q || has_normal_q) begin
								state_d = BK_ISSUE;
							end else begin
								state_d = BK_OUT;
							end
						end
						PH_SQ: begin
							norm_start = 1'b1;
							state_d    = BK_NORM;
						end
						default: state_d = BK_IDLE;
					endcase
				end
			end
			BK_PICK: begin
				if (inf_done || inf_ok) begin
					state_d = BK_ISSUE;
				end
			end
			BK_NORM: begin
				if (norm_done) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!m_tvalid || m_tready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			phase_q      <= PH_BIND;
			pass_q       <= 1'b0;
			row_q        <= 2'd0;
			col_q        <= 2'd0;
			inf_q        <= '0;
			tag_s1       <= '0;
			tag_s2       <= '0;
			m_tvalid     <= 1'b0;
			bone_count_q <= '0;
			has_normal_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BONE_COUNT: bone_count_q <= cfg_data;
					CFG_HAS_NORMAL: has_normal_q <= cfg_data[0];
				endcase
			end
			tag_s1 <= issue ? tag_new : '0;
			tag_s2 <= tag_s1;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (start_vtx) begin
				pass_q  <= 1'b0;
				phase_q <= PH_BIND;
				row_q   <= 2'd0;
				col_q   <= 2'd0;
			end
			if (issue) begin
				if (last_op) begin
					row_q <= 2'd0;
					col_q <= 2'd0;
				end else if (is_xf && col_q == last_col) begin
					row_q <= row_q + 2'd1;
					col_q <= 2'd0;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
			if (state_q == BK_DRAIN && drained) begin
				unique case (phase_q)
					PH_BIND: inf_q   <= '0;
					PH_BONE: phase_q <= PH_WT;
					PH_WT:   inf_q   <= inf_q + 1'b1;
					PH_INV: begin
						if (pass_q) begin
							phase_q <= PH_SQ;
						end else if (has_normal_q) begin
							pass_q  <= 1'b1;
							phase_q <= PH_BIND;
						end
					end
					default: ;
				endcase
			end
			if (state_q == BK_PICK) begin
				if (inf_done) begin
					phase_q <= PH_INV;
				end else if (inf_ok) begin
					phase_q <= PH_BONE;
				end else begin
					inf_q <= inf_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_vtx) begin
			cur_q <= head;
			acc_q <= '0;
			for (int k = 0; k < 3; k++) begin
				pos_out_q[k] <= head.pos[k];
				if (has_normal_q) begin
					rn_q[k] <= head.nrm[k];
				end else begin
					rn_q[k] <= (k == 1) ? ONE_Q16 : '0;
				end
			end
		end
		if (issue) begin
			a_s1 <= a_new;
			b_s1 <= b_new;
		end
		prod_s2 <= mult_a * b_s1;
		if (tag_s2.v) begin
			unique case (tag_s2.kind)
				MK_XF: begin
					if (tag_s2.last) begin
						res_q[tag_s2.row] <= sat32(acc_q + rnd);
						acc_q             <= '0;
					end else begin
						acc_q <= acc_q + rnd;
					end
				end
				MK_WT:   accw_q[tag_s2.row] <= accw_q[tag_s2.row] + rnd;
				MK_SQ:   sumsq_q <= sumsq_q + prod_s2;
				default: ;
			endcase
		end
		if (state_q == BK_DRAIN && drained) begin
			unique case (phase_q)
				PH_BIND: begin
					for (int k = 0; k < 3; k++) begin
						bp_q[k]   <= res_q[k];
						accw_q[k] <= '0;
					end
				end
				PH_INV: begin
					if (pass_q) begin
						sumsq_q <= '0;
					end else begin
						for (int k = 0; k < 3; k++) begin
							pos_out_q[k] <= res_q[k];
							rn_q[k]      <= (k == 1) ? ONE_Q16 : '0;
						end
					end
				end
				default: ;
			endcase
		end
		if (state_q == BK_PICK && !inf_done && inf_ok) begin
			slot_q   <= SLOT_AW'(b_sel);
			weight_q <= w_sel;
		end
		if (state_q == BK_NORM && norm_done) begin
			for (int k = 0; k < 3; k++) begin
				rn_q[k] <= nrm_res[k];
			end
		end
		if (out_load) begin
			out_q <= {rn_q[2], rn_q[1], rn_q[0], pos_out_q[2], pos_out_q[1], pos_out_q[0]};
		end
	end

	assign m_tdata = out_q;

	lbs_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.sumsq  (sumsq_q),
		.t      (res_q),
		.done   (norm_done),
		.rn     (nrm_res)
	);

endmodule

[design/linear_blend_vertex_skinning.sv]
// A load is written to the matrix store when popped; a pass-through vertex goes
// to the output register. A skinned vertex runs bind, bone, weight and inverse bind steps;
// normals add a second pass, a sum of squares, the square root and three divides.
// Throughput is set by the single shared multiplier and the one matrix store read port;
// a two-entry queue keeps accepting transactions while a vertex is in work, until it fills.
// Reset: asynchronous, active low; config clears to zero, matrix store is not cleared.
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Four-influence linear blend skinning engine, Q16.16 fixed point.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning import lbs_pkg::*; #(
	parameter int MAX_BONES  = MAX_BONES_DEF,
	parameter int INFLUENCES = INFLUENCES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// matrix_slot, element_index, element_value, pos_x, pos_y, pos_z,
	// nrm_x, nrm_y, nrm_z, influence_bones, influence_weights, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// operation
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int DEPTH = (MAX_BONES + 2) * 16;
	localparam int AW    = $clog2(DEPTH);

	item_t         head;
	q_stat_t       stat;
	logic          pop;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;

	lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	lbs_ram #(.W(DW), .D(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lbs_back #(.MAX_BONES(MAX_BONES), .INFLUENCES(INFLUENCES), .AW(AW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count != 2'd3) else $error("queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("pop from empty queue");

	a_we_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> pop && head.op == OP_LOAD) else $error("store write without load");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && !pop |=> stat.full) else $error("queue lost an entry");
`endif

endmodule

[test/linear_blend_vertex_skinning_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_test
// Self-checking bench for the skinning engine. Loads bind, inverse bind and
// bone matrices, then streams vertices through directed and random phases
// under several bone counts and normal settings. An in-bench fixed point
// predictor computes each skinned vertex; results are checked in order.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_test;
	import lbs_pkg::*;

	localparam int NSLOT = MAX_BONES_DEF + 2;
	localparam int SL_BIND = MAX_BONES_DEF;
	localparam int SL_INV = MAX_BONES_DEF + 1;

	typedef struct {
		logic signed [31:0] p [3];
		logic signed [31:0] n [3];
	} vtx_out_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	linear_blend_vertex_skinning dut (.*);

	always #10 clk = ~clk;

	logic [31:0] mat [NSLOT*16];
	int unsigned bone_cnt;
	bit nrm_on;
	vtx_out_t pending [$];
	int errors = 0, vertices = 0, checked = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_rx = 0;
	longint cycles = 0;

	// ---------------- predictor ----------------
	function automatic longint sx(logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rnd16(longint p);
		return (p + 32768) >>> 16;
	endfunction

	function automatic void apply_mat(int s, longint v[3], output longint r[3], input bit aff);
		longint acc;
		for (int row = 0; row < 3; row++) begin
			acc = aff ? sx(mat[s*16+12+row]) : 0;
			for (int c = 0; c < 3; c++) acc += rnd16(sx(mat[s*16+c*4+row]) * v[c]);
			r[row] = sat(acc);
		end
	endfunction

	function automatic void blend(longint v[3], output longint r[3], input int nb,
			logic [31:0] bones, logic [63:0] wts, bit aff);
		longint acc[3], t[3];
		longint unsigned w;
		int b;
		acc = '{0, 0, 0};
		for (int i = 0; i < 4; i++) begin
			w = wts[i*16 +: 16];
			b = bones[i*8 +: 8];
			if (w == 0 || b >= nb) continue;
			apply_mat(b, v, t, aff);
			for (int k = 0; k < 3; k++) acc[k] += rnd16(t[k] * longint'(w));
		end
		for (int k = 0; k < 3; k++) r[k] = sat(acc[k]);
	endfunction

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r = 0, bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v -= r + bt;
				r = (r >> 1) + bt;
			end else r >>= 1;
			bt >>= 2;
		end
		return r;
	endfunction

	function automatic vtx_out_t skin_vertex(logic [31:0] ps[3], logic [31:0] ns[3],
			logic [31:0] bones, logic [63:0] wts);
		vtx_out_t o;
		longint p[3], n[3], a[3], b[3], t[3];
		longint unsigned m, s, len, q;
		int nb;
		nb = bone_cnt < 64 ? bone_cnt : 64;
		for (int k = 0; k < 3; k++) begin
			p[k] = sx(ps[k]);
			n[k] = sx(ns[k]);
		end
		if (nb == 0) begin
			for (int k = 0; k < 3; k++) begin
				o.p[k] = ps[k];
				o.n[k] = nrm_on ? ns[k] : (k == 1 ? ONE_Q16 : 0);
			end
			return o;
		end
		apply_mat(SL_BIND, p, a, 1);
		blend(a, b, nb, bones, wts, 1);
		apply_mat(SL_INV, b, t, 1);
		for (int k = 0; k < 3; k++) o.p[k] = t[k][31:0];
		if (!nrm_on) begin
			o.n = '{0, ONE_Q16, 0};
			return o;
		end
		apply_mat(SL_BIND, n, a, 0);
		blend(a, b, nb, bones, wts, 0);
		apply_mat(SL_INV, b, t, 0);
		s = 0;
		for (int k = 0; k < 3; k++) begin
			m = t[k] < 0 ? -t[k] : t[k];
			s += m * m;
		end
		len = isqrt(s);
		for (int k = 0; k < 3; k++) begin
			if (len == 0) o.n[k] = t[k][31:0];
			else begin
				m = t[k] < 0 ? -t[k] : t[k];
				q = (m * 65536 + len / 2) / len;
				o.n[k] = t[k] < 0 ? -longint'(q) : longint'(q);
			end
		end
		return o;
	endfunction

	// ---------------- drivers ----------------
	task automatic send(bit op, logic [6:0] slot, logic [3:0] el, logic [31:0] val,
			logic [31:0] ps[3], logic [31:0] ns[3], logic [31:0] bones, logic [63:0] wts);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tuser <= op;
		s_tdata <= {5'd0, wts, bones, ns[2], ns[1], ns[0], ps[2], ps[1], ps[0], val, el, slot};
		s_tvalid <= 1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == OP_SKIN) begin
			pending.push_back(skin_vertex(ps, ns, bones, wts));
			vertices++;
		end else if (slot < NSLOT) begin
			mat[slot*16+el] = val;
		end
	endtask

	task automatic load(int slot, int el, logic [31:0] val);
		logic [31:0] z[3] = '{0, 0, 0};
		send(OP_LOAD, slot[6:0], el[3:0], val, z, z, 0, 0);
	endtask

	task automatic vertex(logic [31:0] ps[3], logic [31:0] ns[3], logic [31:0] bones,
			logic [63:0] wts);
		send(OP_SKIN, 0, 0, 0, ps, ns, bones, wts);
	endtask

	task automatic drain;
		s_tvalid <= 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_cfg(int bc, bit hn);
		drain();
		cfg_we <= 1; cfg_index <= CFG_BONE_COUNT; cfg_data <= bc[6:0];
		@(posedge clk);
		cfg_index <= CFG_HAS_NORMAL; cfg_data <= {6'd0, hn};
		@(posedge clk);
		cfg_we <= 0;
		bone_cnt = bc;
		nrm_on = hn;
	endtask

	function automatic logic [31:0] rval();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom_range(131072) - 65536;
		endcase
	endfunction

	function automatic logic [31:0] rmat();
		case ($urandom_range(7))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return $urandom_range(163840) - 81920;
		endcase
	endfunction

	task automatic random_vertex();
		logic [31:0] ps[3], ns[3], bones;
		logic [63:0] wts;
		for (int k = 0; k < 3; k++) begin
			ps[k] = rval();
			ns[k] = rval();
		end
		bones = $urandom_range(9) == 0 ? $urandom :
			{8'($urandom_range(70)), 8'($urandom_range(70)),
			 8'($urandom_range(70)), 8'($urandom_range(70))};
		wts = {$urandom, $urandom};
		if ($urandom_range(3) == 0) wts[$urandom_range(3)*16 +: 16] = 0;
		vertex(ps, ns, bones, wts);
	endtask

	// ---------------- receiver and checker ----------------
	always @(posedge clk) begin
		vtx_out_t e;
		logic [31:0] got;
		cycles++;
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected transaction %h", $time, m_tdata);
				errors++;
			end else begin
				e = pending.pop_front();
				checked++;
				for (int k = 0; k < 6; k++) begin
					got = m_tdata[k*32 +: 32];
					if (got !== (k < 3 ? e.p[k] : e.n[k-3])) begin
						$display("%0t: field %0d expected %h actual %h", $time, k,
							k < 3 ? e.p[k] : e.n[k-3], got);
						errors++;
					end
				end
			end
		end
		m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle);
	end

	// ---------------- tests ----------------
	task automatic test_load_all;
		// row 3 of each matrix is never read
		for (int s = 0; s < NSLOT; s++)
			for (int e = 0; e < 16; e++)
				if (e % 4 != 3)
					load(s, e, (s >= 64 && e % 5 == 0) ? ONE_Q16 : rmat());
		load(66, 0, 32'h12345678);
		load(127, 15, 32'hffffffff);
	endtask

	task automatic test_directed;
		logic [31:0] z[3] = '{0, 0, 0};
		logic [31:0] mx[3] = '{32'h7fffffff, 32'h80000000, 32'hffffffff};
		logic [31:0] ones[3] = '{ONE_Q16, ONE_Q16, ONE_Q16};
		set_cfg(0, 0);
		vertex(mx, ones, 0, 0);
		set_cfg(0, 1);
		vertex(mx, mx, '1, '1);
		set_cfg(64, 1);
		vertex(z, z, 0, 0);
		vertex(mx, mx, 32'h3f3f3f3f, '1);
		vertex(ones, ones, 32'h00010203, 64'h4000_4000_4000_4000);
		vertex(ones, ones, 32'hff804140, '1);
		vertex(mx, ones, 32'h01010101, 64'h0000_0000_0000_ffff);
		set_cfg(5, 0);
		vertex(ones, mx, 32'h04050607, 64'h1000_2000_3000_ffff);
		set_cfg(127, 1);
		vertex(ones, ones, 32'h3e3f4000, 64'h0001_0001_0001_0001);
		// zero the 3x3 part of bone 0 for a zero-length normal
		load(0, 0, 0); load(0, 5, 0); load(0, 10, 0);
		load(0, 1, 0); load(0, 2, 0); load(0, 4, 0);
		load(0, 6, 0); load(0, 8, 0); load(0, 9, 0);
		vertex(ones, ones, 32'h00000000, 64'h0000_0000_0000_8000);
		drain();
	endtask

	task automatic test_random(int cnt, int si, int ri);
		send_idle = si;
		recv_idle = ri;
		for (int i = 0; i < cnt; i++) begin
			if ($urandom_range(19) == 0)
				load($urandom_range(63), $urandom_range(15), rmat());
			else random_vertex();
		end
	endtask

	task automatic test_backpressure;
		send_idle = 0;
		recv_idle = 0;
		hold_rx = 1;
		fork
			begin
				repeat (2000) @(posedge clk);
				hold_rx = 0;
			end
			repeat (20) random_vertex();
		join
		drain();
		repeat (10) random_vertex();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_load_all();
		test_directed();
		set_cfg(64, 1);
		test_random(80, 12, 51);
		set_cfg(3, 0);
		test_random(40, 51, 12);
		set_cfg(64, 0);
		test_random(40, 51, 12);
		set_cfg(17, 1);
		test_random(80, 0, 0);
		test_backpressure();
		set_cfg(1, 1);
		test_random(30, 0, 0);
		drain();
		$display("Covered %0d vertices (%0d checked) over bone counts 0..127, normals on/off,",
			vertices, checked);
		$display("full matrix loads, out-of-range slots, idling and long output stalls.");
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) if (cycles > 64'd3000000) begin
		$display("Simulation FAILED");
		$finish;
	end
endmodule

[sim.f]
design/lbs_pkg.sv
design/lbs_ram.sv
design/lbs_front.sv
design/lbs_norm.sv
design/lbs_back.sv
design/linear_blend_vertex_skinning.sv
test/linear_blend_vertex_skinning_test.sv
